// ===== src/grid_home_path_mapper_macros.svh =====
// Assertion macros for the grid home path mapper.
// Every macro expects signals named clk and rst in the scope where it is used.
`ifndef GRID_HOME_PATH_MAPPER_MACROS_SVH
`define GRID_HOME_PATH_MAPPER_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define GHPM_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high
`define GHPM_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ghpm_pkg.sv =====
// Shared types and constants for the grid home path mapper.
// No dependencies; imported by the top level.
`default_nettype none

package ghpm_pkg;

  // Operation codes
  localparam logic [1:0] OP_RUN   = 2'd0;
  localparam logic [1:0] OP_HOME  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_X       = 2'd0;
  localparam logic [1:0] CFG_START_Y       = 2'd1;
  localparam logic [1:0] CFG_START_HEADING = 2'd2;

  // Cell contents
  localparam logic [6:0] UNVISITED  = 7'd99;
  localparam logic [3:0] DIAG_WALLS = 4'hf;

  // Stream widths
  localparam int IN_W  = 16;
  localparam int OUT_W = 32;

  typedef struct packed {
    logic [3:0] walls;
    logic [2:0] back;
    logic [6:0] steps;
  } cell_t;

  // Column step for a heading, north is +y and east is +x
  function automatic logic signed [1:0] step_dx(input logic [2:0] d);
    logic signed [1:0] r;
    case (d)
      3'd1, 3'd2, 3'd3: r = 2'sd1;
      3'd5, 3'd6, 3'd7: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

  // Row step for a heading
  function automatic logic signed [1:0] step_dy(input logic [2:0] d);
    logic signed [1:0] r;
    case (d)
      3'd0, 3'd1, 3'd7: r = 2'sd1;
      3'd3, 3'd4, 3'd5: r = -2'sd1;
      default:          r = 2'sd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/grid_home_path_mapper.sv =====
// Grid home path mapper: one cell memory, a read-modify-write sequencer and the
// current position and heading. Depends on ghpm_pkg and the assertion macros.
//
// Usage:
//  - Input stream s_axis: one transfer per operation (record run, home step,
//    clear map). Output stream m_axis: exactly one result transfer per input.
//  - cfg_we/cfg_index/cfg_data write the start column, row and heading; they
//    take effect at the next clear; reset sets them to zero.
//  - A record run takes one memory access pair per cell step; the next input
//    is taken in the cycle after the result is loaded.
//  - Cell memory has one write and one read port and a registered read; each
//    run step reads the next cell while writing back the one left behind.
//  - Reset and clear drop all the per-cell valid flags at once, so an
//    unwritten cell reads as unvisited (distance 99, or 0 at the start cell).
//    No clearing pass is needed.
//  - When m_axis_tready is low the result holds in the output register; one
//    further item may be worked on and then waits until the register drains.
`default_nettype none
`include "grid_home_path_mapper_macros.svh"

module grid_home_path_mapper
  import ghpm_pkg::*;
#(
  parameter int MAP_SIDE = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Input stream, tdata from bit 0: operation[1:0], direction[2:0], run_length[3:0]
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  // Result stream, tdata from bit 0: pos_x[2:0], pos_y[2:0], heading[2:0],
  // distance_home[6:0], home_direction[2:0], wall_bits[3:0], turn_amount[3:0],
  // at_home, off_map
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,
  // Configuration writes
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [2:0]       cfg_data
);

  localparam int CW    = $clog2(MAP_SIDE);
  localparam int CELLS = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(CELLS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DISP  = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_WALL  = 3'd4;
  localparam logic [2:0] S_WALL2 = 3'd5;
  localparam logic [2:0] S_FETCH = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y);
    return AW'(int'(y) * MAP_SIDE + int'(x));
  endfunction

  logic [2:0]        state, state_next;
  logic [2:0]        start_x, start_y, start_heading;
  logic [1:0]        op_r;
  logic [2:0]        dir_r;
  logic [3:0]        cnt;
  logic [CW-1:0]     cur_x, cur_y;
  logic [2:0]        heading;
  logic [AW-1:0]     home_idx;
  cell_t             cur_word;
  logic [3:0]        turn;
  logic              clipped;
  logic              out_valid;
  logic [OUT_W-1:0]  out_data;

  // Cell memory and its read side
  cell_t             mem [CELLS];
  logic [CELLS-1:0]  valid;
  cell_t             mem_q;
  logic              rd_vld;
  logic [AW-1:0]     rd_addr;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr_in, wr_addr;
  cell_t             wr_data;

  // Input fields
  logic              in_fire;
  logic [1:0]        in_op;
  logic [2:0]        in_dir;
  logic [3:0]        in_len;

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_op         = s_axis_tdata[1:0];
  assign in_dir        = s_axis_tdata[4:2];
  assign in_len        = s_axis_tdata[8:5];

  // Start cell, clamped into the grid
  logic [CW-1:0] sx, sy;
  assign sx = (int'(start_x) >= MAP_SIDE) ? CW'(MAP_SIDE - 1) : CW'(start_x);
  assign sy = (int'(start_y) >= MAP_SIDE) ? CW'(MAP_SIDE - 1) : CW'(start_y);

  // Neighbor positions along the move heading
  logic [2:0]    mv_dir;
  logic [CW:0]   nx1_x, nx1_y, nx2_x, nx2_y;
  logic          nx1_in, nx2_in;
  logic [AW-1:0] cur_addr, nx1_addr, nx2_addr;

  assign mv_dir   = (op_r == OP_HOME) ? cur_word.back : dir_r;
  assign nx1_x    = {1'b0, cur_x} + (CW+1)'(step_dx(mv_dir));
  assign nx1_y    = {1'b0, cur_y} + (CW+1)'(step_dy(mv_dir));
  assign nx2_x    = nx1_x + (CW+1)'(step_dx(dir_r));
  assign nx2_y    = nx1_y + (CW+1)'(step_dy(dir_r));
  assign nx1_in   = (int'(nx1_x) < MAP_SIDE) && (int'(nx1_y) < MAP_SIDE);
  assign nx2_in   = (int'(nx2_x) < MAP_SIDE) && (int'(nx2_y) < MAP_SIDE);
  assign cur_addr = cell_addr(cur_x, cur_y);
  assign nx1_addr = cell_addr(nx1_x[CW-1:0], nx1_y[CW-1:0]);
  assign nx2_addr = cell_addr(nx2_x[CW-1:0], nx2_y[CW-1:0]);

  // Read data, with never-written cells taking their cleared value
  cell_t eff_word;
  always_comb begin
    if (rd_vld) begin
      eff_word = mem_q;
    end else begin
      eff_word.walls = 4'd0;
      eff_word.back  = 3'd0;
      eff_word.steps = (rd_addr == home_idx) ? 7'd0 : UNVISITED;
    end
  end

  // Relax distances between the current cell and the one entered
  cell_t      here_new, there_new;
  logic [7:0] here_p1, there_p1;
  assign here_p1  = {1'b0, cur_word.steps} + 8'd1;
  assign there_p1 = {1'b0, eff_word.steps} + 8'd1;
  always_comb begin
    here_new  = cur_word;
    there_new = eff_word;
    if ({1'b0, eff_word.steps} > here_p1) begin
      there_new.steps = here_p1[6:0];
      there_new.back  = dir_r + 3'd4;
    end else if (there_p1 < {1'b0, cur_word.steps}) begin
      here_new.steps = there_p1[6:0];
      here_new.back  = dir_r;
    end
  end

  // Wall marks at the end of a run
  cell_t wall_word, nbr_word;
  always_comb begin
    wall_word = cur_word;
    if (dir_r[0]) begin
      wall_word.walls = DIAG_WALLS;
    end else begin
      wall_word.walls = cur_word.walls | (4'd1 << dir_r[2:1]);
    end
    nbr_word       = eff_word;
    nbr_word.walls = eff_word.walls | (4'd1 << (dir_r[2:1] ^ 2'b10));
  end

  // Turn toward the stored back direction, folded into -4..4; a half turn
  // counts negative when heading bit 2 is set (headings 4 to 7)
  logic [2:0] turn_d;
  logic [3:0] turn_next;
  assign turn_d    = mv_dir - heading;
  assign turn_next = {(turn_d > 3'd4) || (turn_d == 3'd4 && heading[2]), turn_d};

  // Sequencer and memory port control
  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr_in = cur_addr;
    wr_en      = 1'b0;
    wr_addr    = cur_addr;
    wr_data    = cur_word;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_op == OP_CLEAR) begin
            state_next = S_DONE;
          end else begin
            rd_en      = 1'b1;
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        state_next = S_DISP;
      end
      S_DISP: begin
        case (op_r)
          OP_RUN: begin
            if (cnt == 4'd0 || !nx1_in) begin
              state_next = S_WALL;
            end else begin
              rd_en      = 1'b1;
              rd_addr_in = nx1_addr;
              state_next = S_STEP;
            end
          end
          OP_HOME: begin
            if (cur_word.steps != 7'd0 && nx1_in) begin
              rd_en      = 1'b1;
              rd_addr_in = nx1_addr;
              state_next = S_FETCH;
            end else begin
              state_next = S_DONE;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_STEP: begin
        // write back the cell being left, fetch the one after next
        wr_en   = 1'b1;
        wr_data = here_new;
        if (cnt == 4'd1 || !nx2_in) begin
          state_next = S_WALL;
        end else begin
          rd_en      = 1'b1;
          rd_addr_in = nx2_addr;
          state_next = S_STEP;
        end
      end
      S_WALL: begin
        wr_en   = 1'b1;
        wr_data = wall_word;
        if (!dir_r[0] && nx1_in) begin
          rd_en      = 1'b1;
          rd_addr_in = nx1_addr;
          state_next = S_WALL2;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WALL2: begin
        wr_en      = 1'b1;
        wr_addr    = rd_addr;
        wr_data    = nbr_word;
        state_next = S_DONE;
      end
      S_FETCH: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Cell memory, synchronous read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q   <= mem[rd_addr_in];
      rd_vld  <= valid[rd_addr_in];
      rd_addr <= rd_addr_in;
    end
  end

  // Per-cell written flags, dropped by reset and clear
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (in_fire && in_op == OP_CLEAR) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Control, position and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      start_x       <= 3'd0;
      start_y       <= 3'd0;
      start_heading <= 3'd0;
      cur_x         <= '0;
      cur_y         <= '0;
      heading       <= 3'd0;
      home_idx      <= '0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        case (cfg_index)
          CFG_START_X:       start_x       <= cfg_data;
          CFG_START_Y:       start_y       <= cfg_data;
          CFG_START_HEADING: start_heading <= cfg_data;
          default: ;
        endcase
      end

      // Load the output register when free, drop it after a transfer
      if (state == S_DONE && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            op_r    <= in_op;
            dir_r   <= in_dir;
            cnt     <= in_len;
            clipped <= 1'b0;
            turn    <= 4'd0;
            if (in_op == OP_CLEAR) begin
              cur_x    <= sx;
              cur_y    <= sy;
              heading  <= start_heading;
              home_idx <= cell_addr(sx, sy);
              cur_word <= '0;
            end
          end
        end
        S_LOAD: begin
          cur_word <= eff_word;
        end
        S_DISP: begin
          if (op_r == OP_RUN) begin
            if (cnt != 4'd0 && !nx1_in) begin
              clipped <= 1'b1;
            end
          end else if (op_r == OP_HOME && cur_word.steps != 7'd0) begin
            heading <= mv_dir;
            turn    <= turn_next;
            if (nx1_in) begin
              cur_x <= nx1_x[CW-1:0];
              cur_y <= nx1_y[CW-1:0];
            end else begin
              clipped <= 1'b1;
            end
          end
        end
        S_STEP: begin
          cur_x    <= nx1_x[CW-1:0];
          cur_y    <= nx1_y[CW-1:0];
          cur_word <= there_new;
          cnt      <= cnt - 4'd1;
          if (cnt != 4'd1 && !nx2_in) begin
            clipped <= 1'b1;
          end
        end
        S_WALL: begin
          cur_word <= wall_word;
        end
        S_FETCH: begin
          cur_word <= eff_word;
        end
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_data <= {3'b000, clipped, (cur_word.steps == 7'd0), turn,
                         cur_word.walls, cur_word.back, cur_word.steps,
                         heading, 3'(cur_y), 3'(cur_x)};
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Checks
  `GHPM_IMPLIES(a_no_same_cell, rd_en && wr_en, rd_addr_in != wr_addr, "read and write hit one cell")
  `GHPM_IMPLIES(a_step_count, state == S_STEP, cnt != 4'd0, "run step with no cells left")
  `GHPM_IMPLIES(a_write_states, wr_en, state == S_STEP || state == S_WALL || state == S_WALL2, "cell write outside a run")
  `GHPM_NEXT(a_result_loaded, state == S_DONE && (!out_valid || m_axis_tready), out_valid && state == S_IDLE, "result not loaded")

endmodule

`default_nettype wire
